// ===== rtl/stli_pkg.sv =====
// Package for the sorted-table interpolator: request and status codes, FSM states.
// Used by the top level, the divider, the checker and the testbench; depends on nothing.
package stli_pkg;
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_CLEAR  = 2'd1;
  localparam logic [1:0] REQ_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_NONPOS = 2'd1;
  localparam logic [1:0] ST_EMPTY  = 2'd2;
  localparam logic [1:0] ST_FULL   = 2'd3;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_SRCH   = 10'b0000000010,
    S_SWAIT  = 10'b0000000100,
    S_DECIDE = 10'b0000001000,
    S_SHIFT  = 10'b0000010000,
    S_RDLO   = 10'b0000100000,
    S_RDWAIT = 10'b0001000000,
    S_MUL    = 10'b0010000000,
    S_DIV    = 10'b0100000000,
    S_OUT    = 10'b1000000000
  } state_t;

  typedef struct packed {
    logic        start;
    logic [63:0] num;
    logic [32:0] den;
  } div_req_t;
endpackage

// ===== rtl/sorted_table_linear_interpolator_core.sv =====
// Top level of the sorted-table interpolator: FSM, key/value RAMs, divider.
// Depends on stli_pkg, stli_ram and stli_div.
//
// Usage: requests enter on the in_ stream (insert, clear, query); each gives
// exactly one response on the out_ stream (interpolated volatility and status).
// Breakpoints live in two synchronous RAMs of ENTRIES words, kept sorted by
// strike. One request is in work at a time; in_tready is high only while idle.
// Flow per request: clear, an unused code, a zero insert value or a query of an
// empty table goes straight to the output stage. Query and insert first run a
// binary search of k steps (k <= clog2(ENTRIES)+1), each a RAM read then a compare.
// An interpolated query then reads the lower entry, multiplies, starts the
// divider, waits for its quotient bits and picks up the quotient. An insert of
// a new strike into a table that is not full moves each entry above the slot up
// (read then write) and ends with the write of the new breakpoint.
// The response sits in an output register, so the next request is taken while
// it waits. A later result holds in the last state while out_tready is low.
// Reset empties the table (entry count to zero); RAM contents are undefined.
module sorted_table_linear_interpolator_core
  import stli_pkg::*;
#(
  parameter int ENTRIES = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // [31:0] strike, [63:32] vol_value
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] vol_out
  output logic [1:0]  out_tuser   // [1:0] status
);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL = CW'(ENTRIES);

  state_t state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt, lo_r, lo_nxt, hi_r, hi_nxt, idx_r, idx_nxt;
  logic [1:0]  req_r, req_nxt;
  logic signed [31:0] x_r, x_nxt;
  logic [31:0] val_r, val_nxt;
  logic [31:0] vol_r, vol_nxt;
  logic [1:0]  st_r, st_nxt;
  logic        ov_r, ov_nxt;
  logic [31:0] odata_r, odata_nxt;
  logic [1:0]  ouser_r, ouser_nxt;
  logic [1:0]  ph_r, ph_nxt;
  logic signed [31:0] kd_r, kd_nxt;
  logic [31:0] vd_r, vd_nxt;
  logic [63:0] prod_r, prod_nxt;
  logic        neg_r, neg_nxt;
  logic [32:0] den_r, den_nxt;
  logic [32:0] dx_r, dx_nxt;
  logic [31:0] mag_r, mag_nxt;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   kwd, vwd, krd, vrd;
  div_req_t      dreq;
  logic          ddone;
  logic [63:0]   dq;
  logic [CW-1:0] mid;

  stli_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_key (
    .clk(clk), .we(we), .waddr(waddr), .wdata(kwd), .raddr(raddr), .rdata(krd));
  stli_ram #(.WIDTH(32), .DEPTH(ENTRIES)) u_val (
    .clk(clk), .we(we), .waddr(waddr), .wdata(vwd), .raddr(raddr), .rdata(vrd));
  stli_div u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .done(ddone), .quot(dq));

  assign mid = lo_r + ((hi_r - lo_r) >> 1);
  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r; cnt_nxt = cnt_r; lo_nxt = lo_r; hi_nxt = hi_r;
    idx_nxt = idx_r; req_nxt = req_r; x_nxt = x_r; val_nxt = val_r;
    vol_nxt = vol_r; st_nxt = st_r; ov_nxt = ov_r; ph_nxt = ph_r;
    odata_nxt = odata_r; ouser_nxt = ouser_r;
    kd_nxt = kd_r; vd_nxt = vd_r; prod_nxt = prod_r; neg_nxt = neg_r;
    den_nxt = den_r; dx_nxt = dx_r; mag_nxt = mag_r;
    we = 1'b0; waddr = '0; kwd = x_r; vwd = val_r; raddr = mid[AW-1:0];
    dreq.start = 1'b0; dreq.num = prod_r; dreq.den = den_r;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          req_nxt = in_tuser; x_nxt = in_tdata[31:0]; val_nxt = in_tdata[63:32];
          lo_nxt = '0; hi_nxt = cnt_r; vol_nxt = '0; st_nxt = ST_OK;
          state_nxt = S_OUT;
          if (in_tuser == REQ_CLEAR) cnt_nxt = '0;
          else if (in_tuser == REQ_INSERT) begin
            if (in_tdata[63:32] == 32'd0) st_nxt = ST_NONPOS;
            else state_nxt = S_SRCH;
          end else if (in_tuser == REQ_QUERY) begin
            if (cnt_r == '0) st_nxt = ST_EMPTY;
            else state_nxt = S_SRCH;
          end
        end
      end
      S_SRCH: begin
        if (lo_r < hi_r) state_nxt = S_SWAIT;
        else begin
          raddr = (lo_r < cnt_r) ? lo_r[AW-1:0] : AW'(cnt_r - 1'b1);
          state_nxt = S_DECIDE;
        end
      end
      S_SWAIT: begin
        if ($signed(krd) < x_r) lo_nxt = mid + 1'b1;
        else hi_nxt = mid;
        state_nxt = S_SRCH;
      end
      S_DECIDE: begin
        // krd/vrd hold entry lo (or the last entry when lo is past the end)
        state_nxt = S_OUT;
        if (req_r == REQ_INSERT) begin
          if (lo_r < cnt_r && $signed(krd) == x_r) begin
            we = 1'b1; waddr = lo_r[AW-1:0]; vol_nxt = val_r;
          end else if (cnt_r >= FULL) st_nxt = ST_FULL;
          else begin
            idx_nxt = cnt_r; ph_nxt = 2'd0; state_nxt = S_SHIFT;
          end
        end else begin
          if ((lo_r < cnt_r && $signed(krd) == x_r) || lo_r == '0 || lo_r >= cnt_r)
            vol_nxt = vrd;
          else begin
            kd_nxt = krd; vd_nxt = vrd; state_nxt = S_RDLO;
          end
        end
      end
      S_SHIFT: begin
        if (idx_r == lo_r) begin
          we = 1'b1; waddr = lo_r[AW-1:0];
          cnt_nxt = cnt_r + 1'b1; vol_nxt = val_r; state_nxt = S_OUT;
        end else if (ph_r == 2'd0) begin
          raddr = AW'(idx_r - 1'b1); ph_nxt = 2'd1;
        end else begin
          we = 1'b1; waddr = idx_r[AW-1:0]; kwd = krd; vwd = vrd;
          idx_nxt = idx_r - 1'b1; ph_nxt = 2'd0;
        end
      end
      S_RDLO: begin
        raddr = AW'(lo_r - 1'b1); state_nxt = S_RDWAIT;
      end
      S_RDWAIT: begin
        // kd/vd hold upper entry, krd/vrd the lower one
        den_nxt = {kd_r[31], kd_r} - {krd[31], krd};
        dx_nxt = {x_r[31], x_r} - {krd[31], krd};
        neg_nxt = (vd_r < vrd);
        mag_nxt = (vd_r >= vrd) ? vd_r - vrd : vrd - vd_r;
        vd_nxt = vrd;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        prod_nxt = 64'(mag_r) * 64'(dx_r[31:0]);
        state_nxt = S_DIV; ph_nxt = 2'd0;
      end
      S_DIV: begin
        if (ph_r == 2'd0) begin
          dreq.start = 1'b1; ph_nxt = 2'd1;
        end else if (ddone) begin
          vol_nxt = neg_r ? vd_r - dq[31:0] : vd_r + dq[31:0];
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        // hand over once the output register is free or being drained
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; odata_nxt = vol_r; ouser_nxt = st_r; state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; cnt_r <= '0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
    end
    lo_r <= lo_nxt; hi_r <= hi_nxt; idx_r <= idx_nxt; req_r <= req_nxt;
    x_r <= x_nxt; val_r <= val_nxt; vol_r <= vol_nxt; st_r <= st_nxt;
    odata_r <= odata_nxt; ouser_r <= ouser_nxt;
    ph_r <= ph_nxt; kd_r <= kd_nxt; vd_r <= vd_nxt; prod_r <= prod_nxt;
    neg_r <= neg_nxt; den_r <= den_nxt; dx_r <= dx_nxt; mag_r <= mag_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = odata_r;
  assign out_tuser  = ouser_r;
endmodule

// ===== rtl/stli_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module stli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ===== rtl/stli_div.sv =====
// Restoring divider, one quotient bit per cycle, 64-bit dividend by 33-bit divisor.
// Depends on stli_pkg for the request struct.
module stli_div
  import stli_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  div_req_t    req,
  output logic        done,
  output logic [63:0] quot
);
  logic [63:0] q_r, q_nxt;
  logic [33:0] rem_r, rem_nxt;
  logic [32:0] den_r;
  logic [6:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;
  logic [33:0] trial;

  always_comb begin
    q_nxt = q_r; rem_nxt = rem_r; cnt_nxt = cnt_r; busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[32:0], q_r[63]};
    if (req.start) begin
      q_nxt = req.num; rem_nxt = '0; cnt_nxt = 7'd64; busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = trial - {1'b0, den_r};
        q_nxt = {q_r[62:0], 1'b1};
      end else begin
        rem_nxt = trial;
        q_nxt = {q_r[62:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      // flag the quotient once the last bit has landed
      if (cnt_r == 7'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0; done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt; done_r <= done_nxt;
    end
    q_r <= q_nxt; rem_r <= rem_nxt;
    if (req.start) den_r <= req.den;
  end

  assign done = done_r;
  assign quot = q_r;
endmodule

// ===== rtl/stli_checker.sv =====
// Port-level checker for the interpolator, bound to the top level.
// Depends on stli_pkg for the status codes.
module stli_checker
  import stli_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic [1:0]  out_tuser
);
  // error responses carry a zero value
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser != ST_OK |-> out_tdata == 32'd0)
    else $error("error status with nonzero value");
  // a fresh response only follows a cycle with the input side busy
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> !$past(in_tready))
    else $error("response appeared straight out of idle");
  // an accepted request leaves the input side closed next cycle
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready right after accept");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled response changed");
endmodule

bind sorted_table_linear_interpolator_core stli_checker u_chk (
  .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
  .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
  .out_tuser(out_tuser));

// ===== tb/sorted_table_linear_interpolator_core_tb.sv =====
// Testbench for sorted_table_linear_interpolator_core: a directed table of requests, a
// fill-to-capacity run, then random insert/clear/query traffic checked against a
// behavioural breakpoint table. Depends on stli_pkg and the RTL of the block.
`timescale 1ns / 1ps

module sorted_table_linear_interpolator_core_tb
  import stli_pkg::*;
;

  localparam int ENTRIES     = 32;
  localparam int NUM_RANDOM  = 1800;
  localparam int STALL_LIMIT = 20000;

  typedef struct {
    logic [1:0]  req;
    logic [31:0] strike;
    logic [31:0] vol;
    logic        fixed;     // expected response typed in below
    logic [31:0] exp_vol;
    logic [1:0]  exp_status;
  } dir_row_t;

  typedef struct {
    logic [31:0] vol;
    logic [1:0]  status;
  } resp_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [63:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;
  logic [1:0]  out_tuser;

  // Behavioural breakpoint table
  logic signed [31:0] bp_key [ENTRIES];
  logic        [31:0] bp_val [ENTRIES];
  int                 bp_count;

  resp_t   pending_resp[$];
  int      fail_count;
  int      idle_cycles;
  bit      rx_quiet;
  bit      tx_quiet;

  sorted_table_linear_interpolator_core #(.ENTRIES(ENTRIES)) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // First index whose key is not below x
  function automatic int find_slot(logic signed [31:0] x);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = bp_count;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (bp_key[mid] < x) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  function automatic logic [31:0] blend_vol(int up, logic signed [31:0] x);
    logic [63:0] dx;
    logic [63:0] span;
    logic [63:0] mag;
    logic [63:0] q;
    dx   = 64'(longint'(x) - longint'(bp_key[up-1]));
    span = 64'(longint'(bp_key[up]) - longint'(bp_key[up-1]));
    if (bp_val[up] >= bp_val[up-1]) begin
      mag = 64'(bp_val[up] - bp_val[up-1]);
      q   = (mag * dx) / span;
      return bp_val[up-1] + q[31:0];
    end
    mag = 64'(bp_val[up-1] - bp_val[up]);
    q   = (mag * dx) / span;
    return bp_val[up-1] - q[31:0];
  endfunction

  // Apply one request to the table and return its response
  function automatic resp_t apply_request(logic [1:0] req, logic signed [31:0] x,
                                          logic [31:0] v);
    resp_t r;
    int    p;
    r.vol    = '0;
    r.status = ST_OK;
    case (req)
      REQ_INSERT: begin
        if (v == 0) begin
          r.status = ST_NONPOS;
        end else begin
          p = find_slot(x);
          if (p < bp_count && bp_key[p] == x) begin
            bp_val[p] = v;
            r.vol = v;
          end else if (bp_count >= ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            for (int i = bp_count; i > p; i--) begin
              bp_key[i] = bp_key[i-1];
              bp_val[i] = bp_val[i-1];
            end
            bp_key[p] = x;
            bp_val[p] = v;
            bp_count++;
            r.vol = v;
          end
        end
      end
      REQ_CLEAR: bp_count = 0;
      REQ_QUERY: begin
        if (bp_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          p = find_slot(x);
          if (p < bp_count && bp_key[p] == x) r.vol = bp_val[p];
          else if (p == 0) r.vol = bp_val[0];
          else if (p >= bp_count) r.vol = bp_val[bp_count-1];
          else r.vol = blend_vol(p, x);
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // Hold valid across back-to-back requests; drop it only while idling
  task automatic send_request(logic [1:0] req, logic [31:0] x, logic [31:0] v);
    while (!tx_quiet && $urandom_range(99) < 20) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {v, x};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_resp.insert(pending_resp.size(), apply_request(req, x, v));
    @(negedge clk);
  endtask

  function automatic logic [31:0] pick_strike();
    case ($urandom_range(9))
      0:       return {1'b1, 31'h0} + $urandom_range(3);
      1:       return 32'h7fff_ffff - $urandom_range(3);
      2, 3, 4: return 32'(($urandom_range(40) - 20) * 32'h0010_0000);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_vol();
    case ($urandom_range(9))
      0:       return 32'h0;
      1:       return 32'hffff_ffff;
      2:       return 32'h1;
      default: return $urandom;
    endcase
  endfunction

  // Receiver: random back-pressure and checking
  always @(negedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else out_tready <= rx_quiet || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    resp_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_resp.size() == 0) begin
        $error("unexpected response vol_out=%h status=%0d", out_tdata, out_tuser);
        fail_count++;
      end else begin
        e = pending_resp.pop_front();
        if (out_tdata !== e.vol) begin
          $error("vol_out: expected %h, got %h", e.vol, out_tdata);
          fail_count++;
        end
        if (out_tuser !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_tuser);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no handshake
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    dir_row_t plan[$];
    int       n;
    logic [1:0] kind;
    bp_count    = 0;
    rx_quiet    = 1'b0;
    tx_quiet    = 1'b0;
    rst_n       = 1'b0;
    in_tvalid   = 1'b0;
    in_tdata    = '0;
    in_tuser    = REQ_INSERT;

    plan = '{
      '{REQ_QUERY,  32'h0,         32'h5,         1'b1, 32'h0,         ST_EMPTY},
      '{REQ_INSERT, 32'h0100_0000, 32'h0,         1'b1, 32'h0,         ST_NONPOS},
      '{REQ_INSERT, 32'h8000_0000, 32'hffff_ffff, 1'b1, 32'hffff_ffff, ST_OK},
      '{REQ_INSERT, 32'h7fff_ffff, 32'h1,         1'b1, 32'h1,         ST_OK},
      '{REQ_QUERY,  32'h0,         32'h0,         1'b0, 32'h0,         ST_OK},
      '{REQ_QUERY,  32'h8000_0000, 32'h0,         1'b1, 32'hffff_ffff, ST_OK},
      '{REQ_QUERY,  32'h7fff_ffff, 32'h0,         1'b1, 32'h1,         ST_OK},
      '{REQ_INSERT, 32'h0100_0000, 32'h0200_0000, 1'b0, 32'h0,         ST_OK},
      '{REQ_QUERY,  32'h0080_0000, 32'h0,         1'b0, 32'h0,         ST_OK},
      '{REQ_QUERY,  32'hff00_0000, 32'h0,         1'b0, 32'h0,         ST_OK},
      '{REQ_INSERT, 32'h0100_0000, 32'h0300_0000, 1'b1, 32'h0300_0000, ST_OK},
      '{2'd3,       32'h1234_5678, 32'h9abc_def0, 1'b1, 32'h0,         ST_OK},
      '{REQ_CLEAR,  32'h0,         32'h0,         1'b1, 32'h0,         ST_OK},
      '{REQ_QUERY,  32'h0100_0000, 32'h0,         1'b1, 32'h0,         ST_EMPTY},
      '{REQ_INSERT, 32'h0000_0010, 32'h0000_0100, 1'b1, 32'h0000_0100, ST_OK},
      '{REQ_QUERY,  32'h8000_0000, 32'h0,         1'b1, 32'h0000_0100, ST_OK},
      '{REQ_QUERY,  32'h7fff_ffff, 32'h0,         1'b1, 32'h0000_0100, ST_OK}
    };

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (plan[i]) begin
      send_request(plan[i].req, plan[i].strike, plan[i].vol);
      // swap the predicted response for the typed-in one
      if (plan[i].fixed) pending_resp[$] = '{plan[i].exp_vol, plan[i].exp_status};
    end

    // Fill to capacity, then hit the full table with new and existing strikes
    send_request(REQ_CLEAR, 32'h0, 32'h0);
    for (int i = 0; i < ENTRIES; i++)
      send_request(REQ_INSERT, 32'((ENTRIES - i) * 32'h0040_0000), $urandom | 1);
    send_request(REQ_INSERT, 32'h0, 32'h7);
    send_request(REQ_INSERT, 32'h0040_0000, 32'h9);
    send_request(REQ_QUERY, 32'h0050_0000, 32'h0);

    // Random runs: mostly fill-and-query with the odd clear, stray code or zero value
    n = 0;
    while (n < NUM_RANDOM) begin
      tx_quiet = (n >= 600 && n < 800);
      rx_quiet = tx_quiet;
      case ($urandom_range(99))
        0, 1, 2:       kind = REQ_CLEAR;
        3:             kind = 2'd3;
        default:       kind = ($urandom_range(99) < 45) ? REQ_INSERT : REQ_QUERY;
      endcase
      send_request(kind, pick_strike(), pick_vol());
      n++;
    end
    in_tvalid <= 1'b0;
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;

    while (pending_resp.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/stli_pkg.sv
rtl/stli_ram.sv
rtl/stli_div.sv
rtl/sorted_table_linear_interpolator_core.sv
rtl/stli_checker.sv
tb/sorted_table_linear_interpolator_core_tb.sv
